// ----- rtl/prs_pkg.sv -----
// shared constants, types and helpers for the position ramp block
package prs_pkg;

   localparam int unsigned POS_W      = 15;
   localparam int unsigned TARGET_W   = 17;
   localparam int unsigned STEP_W     = 13;
   localparam int unsigned ZONE_W     = 16;
   localparam int unsigned SPEED_W    = 20;
   localparam int unsigned RATIO_W    = 17;
   localparam int unsigned DIVIDEND_W = 28;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 20;

   localparam int unsigned POS_LIMIT     = 30200;
   localparam int unsigned RATIO_ONE     = 65536;
   localparam int unsigned RATIO_DEFAULT = 3277;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_ZONE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RATIO = 2'd2;

   typedef struct packed {
      logic              done;
      logic [STEP_W-1:0] quo;
   } div_result_type;

   function automatic logic [STEP_W-1:0] at_least_one(logic [STEP_W-1:0] v);
      return (v == '0) ? STEP_W'(1) : v;
   endfunction

endpackage

// ----- rtl/prs_div.sv -----
// iterative restoring divider, one quotient bit per cycle, rounds the quotient up
module prs_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [prs_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [prs_pkg::ZONE_W-1:0]          divisor,
   output prs_pkg::div_result_type             result
);

   localparam int unsigned CNT_W = $clog2(prs_pkg::DIVIDEND_W + 1);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   logic [prs_pkg::ZONE_W-1:0]        rem_ff, rem_in;
   logic [prs_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [prs_pkg::ZONE_W:0]          trial;
   logic [prs_pkg::ZONE_W:0]          trial_sub;
   logic                              fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[prs_pkg::DIVIDEND_W-1]};
      trial_sub = trial - {1'b0, divisor};
      fits      = trial >= {1'b0, divisor};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(prs_pkg::DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[prs_pkg::ZONE_W-1:0] : trial[prs_pkg::ZONE_W-1:0];
         quo_in = {quo_ff[prs_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // quotient never exceeds the full step, so the low bits carry it all
   assign result.done = done_ff;
   assign result.quo  = quo_ff[prs_pkg::STEP_W-1:0]
                      + prs_pkg::STEP_W'(rem_ff != '0);

endmodule

// ----- rtl/position_ramp_with_slowdown.sv -----
// top level of the position ramp generator with a slowdown zone
// Moves a stored position toward each requested target by one step and returns
// the new position, clamped to 0..30200.
// req channel: req_valid/req_stall with req_target (signed). One request is
// taken at a time; req_stall stays high while a request is being worked on.
// rsp channel: rsp_valid/rsp_stall with rsp_position, one response per request.
// csr channel: csr_valid/csr_ready, csr_index selects max_step (0), slow_zone
// (1) or min_ratio (2); csr_ready is always high. Write only while idle.
// Outside the slow zone the step is found in the check state; inside it the
// step is set by the shared 20x32 multiplier (three passes) and the
// bit-serial divider that divides by the zone width.
// The finish state waits until the response register is free.
// A new request is taken while the previous response still waits; the result
// of that request is held until the response register frees up.
// Reset: synchronous, clears the position to 0 and loads the register defaults
// max_step 2560, slow_zone 4200, min_ratio 6554.
module position_ramp_with_slowdown (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [prs_pkg::TARGET_W-1:0]  req_target,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [prs_pkg::POS_W-1:0]            rsp_position,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [prs_pkg::CSR_DATA_W-1:0]       csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_MUL_RZ, ST_MUL_D, ST_SUM, ST_MUL_S,
      ST_DIV_START, ST_DIV_WAIT, ST_FINISH
   } state_type;

   localparam int unsigned PROD_W = prs_pkg::SPEED_W + 32;

   state_type                               state_ff, state_in;
   logic [prs_pkg::SPEED_W-1:0]             max_step_ff, max_step_in;
   logic [prs_pkg::ZONE_W-1:0]              slow_zone_ff, slow_zone_in;
   logic [prs_pkg::RATIO_W-1:0]             min_ratio_ff, min_ratio_in;
   logic [prs_pkg::POS_W-1:0]               cur_ff, cur_in;
   logic signed [prs_pkg::TARGET_W-1:0]     target_ff, target_in;
   logic [prs_pkg::TARGET_W-1:0]            dist_ff, dist_in;
   logic                                    up_ff, up_in;
   logic [PROD_W-1:0]                       prod_ff, prod_in;
   logic [31:0]                             acc_ff, acc_in;
   logic [prs_pkg::STEP_W-1:0]              step_ff, step_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [prs_pkg::POS_W-1:0]               rsp_position_ff, rsp_position_in;

   logic [prs_pkg::RATIO_W-1:0]             ratio_eff;
   logic [prs_pkg::RATIO_W-1:0]             ratio_inv;
   logic [prs_pkg::TARGET_W:0]              diff;
   logic [prs_pkg::TARGET_W:0]              diff_neg;
   logic [prs_pkg::STEP_W-1:0]              fast_step;
   logic [prs_pkg::SPEED_W-1:0]             mul_a;
   logic [31:0]                             mul_b;
   logic [prs_pkg::DIVIDEND_W-1:0]          dividend;
   logic [prs_pkg::TARGET_W:0]              sum_up;
   logic [prs_pkg::TARGET_W:0]              sum_dn;
   logic [prs_pkg::TARGET_W:0]              moved;
   logic [prs_pkg::POS_W-1:0]               next_pos;
   logic                                    accept;
   logic                                    out_free;
   logic                                    div_start;
   prs_pkg::div_result_type                 div_res;

   prs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (slow_zone_ff),
      .result   (div_res)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign div_start    = (state_ff == ST_DIV_START);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;

   always_comb begin
      priority if (min_ratio_ff == '0) begin
         ratio_eff = prs_pkg::RATIO_W'(prs_pkg::RATIO_DEFAULT);
      end else if (min_ratio_ff > prs_pkg::RATIO_W'(prs_pkg::RATIO_ONE)) begin
         ratio_eff = prs_pkg::RATIO_W'(prs_pkg::RATIO_ONE);
      end else begin
         ratio_eff = min_ratio_ff;
      end
      ratio_inv = prs_pkg::RATIO_W'(prs_pkg::RATIO_ONE) - ratio_eff;

      diff     = {req_target[prs_pkg::TARGET_W-1], req_target}
               - {3'b000, cur_ff};
      diff_neg = -diff;
      fast_step = {1'b0, max_step_ff[prs_pkg::SPEED_W-1:8]}
                + prs_pkg::STEP_W'(max_step_ff[7:0] != '0);

      // shared multiplier operand select
      unique case (state_ff)
         ST_MUL_RZ: begin
            mul_a = prs_pkg::SPEED_W'(ratio_eff);
            mul_b = 32'(slow_zone_ff);
         end
         ST_MUL_D: begin
            mul_a = prs_pkg::SPEED_W'(ratio_inv);
            mul_b = 32'(dist_ff[prs_pkg::ZONE_W-1:0]);
         end
         ST_MUL_S: begin
            mul_a = max_step_ff;
            mul_b = acc_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      // ceil of the product over 2^24 before the zone divide
      dividend = prod_ff[PROD_W-1:24] + prs_pkg::DIVIDEND_W'(prod_ff[23:0] != '0);

      sum_up = {3'b000, cur_ff} + (prs_pkg::TARGET_W + 1)'(step_ff);
      sum_dn = {3'b000, cur_ff} - (prs_pkg::TARGET_W + 1)'(step_ff);
      priority if (dist_ff <= prs_pkg::TARGET_W'(step_ff)) begin
         moved = {target_ff[prs_pkg::TARGET_W-1], target_ff};
      end else if (up_ff) begin
         moved = sum_up;
      end else begin
         moved = sum_dn;
      end
      priority if (moved[prs_pkg::TARGET_W]) begin
         next_pos = '0;
      end else if (moved > (prs_pkg::TARGET_W + 1)'(prs_pkg::POS_LIMIT)) begin
         next_pos = prs_pkg::POS_W'(prs_pkg::POS_LIMIT);
      end else begin
         next_pos = moved[prs_pkg::POS_W-1:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      max_step_in     = max_step_ff;
      slow_zone_in    = slow_zone_ff;
      min_ratio_in    = min_ratio_ff;
      cur_in          = cur_ff;
      target_in       = target_ff;
      dist_in         = dist_ff;
      up_in           = up_ff;
      prod_in         = prod_ff;
      acc_in          = acc_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_position_in = rsp_position_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            prs_pkg::REG_MAX_STEP:  max_step_in  = csr_data;
            prs_pkg::REG_SLOW_ZONE: slow_zone_in = csr_data[prs_pkg::ZONE_W-1:0];
            prs_pkg::REG_MIN_RATIO: min_ratio_in = csr_data[prs_pkg::RATIO_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               target_in = req_target;
               dist_in   = diff[prs_pkg::TARGET_W] ? diff_neg[prs_pkg::TARGET_W-1:0]
                                                   : diff[prs_pkg::TARGET_W-1:0];
               up_in     = !diff[prs_pkg::TARGET_W];
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (dist_ff < prs_pkg::TARGET_W'(slow_zone_ff)) begin
               state_in = ST_MUL_RZ;
            end else begin
               step_in  = prs_pkg::at_least_one(fast_step);
               state_in = ST_FINISH;
            end
         end
         ST_MUL_RZ: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            acc_in   = prod_ff[31:0];
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // stays below 2^32 since the distance is inside the zone
            acc_in   = acc_ff + prod_ff[31:0];
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            prod_in  = PROD_W'(mul_a) * PROD_W'(mul_b);
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_res.done) begin
               step_in  = prs_pkg::at_least_one(div_res.quo);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cur_in          = next_pos;
               rsp_valid_in    = 1'b1;
               rsp_position_in = next_pos;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_step_ff  <= prs_pkg::SPEED_W'(2560);
         slow_zone_ff <= prs_pkg::ZONE_W'(4200);
         min_ratio_ff <= prs_pkg::RATIO_W'(6554);
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_step_ff  <= max_step_in;
         slow_zone_ff <= slow_zone_in;
         min_ratio_ff <= min_ratio_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff       <= target_in;
      dist_ff         <= dist_in;
      up_ff           <= up_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      step_ff         <= step_in;
      rsp_position_ff <= rsp_position_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CHECK)
      else $error("accepted request did not start the sequence");

   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |-> step_ff != '0)
      else $error("zero step at finish");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_position_ff <= prs_pkg::POS_W'(prs_pkg::POS_LIMIT))
      else $error("position out of range");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_resp_matches_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && out_free) |=> rsp_valid_ff && rsp_position_ff == cur_ff)
      else $error("response does not match stored position");

endmodule

// ----- sim/tb_position_ramp_with_slowdown.sv -----
// testbench for the position ramp block: directed and random targets against a predictor
module tb_position_ramp_with_slowdown;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 300;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   logic signed [prs_pkg::TARGET_W-1:0]  req_target;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   logic [prs_pkg::POS_W-1:0]            rsp_position;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [prs_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [prs_pkg::CSR_DATA_W-1:0]       csr_data;

   // predictor copy of the block's registers and position
   logic [prs_pkg::SPEED_W-1:0]          cfg_step;
   logic [prs_pkg::ZONE_W-1:0]           cfg_zone;
   logic [prs_pkg::RATIO_W-1:0]          cfg_ratio;
   logic [prs_pkg::POS_W-1:0]            cur_pos;
   logic [prs_pkg::POS_W-1:0]            expected_positions[$];
   logic [prs_pkg::POS_W-1:0]            due_position;

   int errors;
   int cycle_count;
   int hold_left;
   int burst_left;
   bit idle_on;

   position_ramp_with_slowdown dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_target   (req_target),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_position (rsp_position),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // new position after one tick toward target
   function automatic logic [prs_pkg::POS_W-1:0] next_position(
      input logic signed [prs_pkg::TARGET_W-1:0] target);
      longint tgt, pos, gap, nxt;
      longint unsigned s, z, r, d, step;
      tgt = target;
      pos = cur_pos;
      gap = tgt - pos;
      if (gap < 0) gap = -gap;
      if (gap == 0) return cur_pos;
      s = cfg_step;
      z = cfg_zone;
      d = gap;
      r = (cfg_ratio == '0) ? prs_pkg::RATIO_DEFAULT : cfg_ratio;
      if (r > prs_pkg::RATIO_ONE) r = prs_pkg::RATIO_ONE;
      // inside the zone the step scales linearly from r at the target to 1 at the edge
      if (d < z)
         step = (s * (r * z + (prs_pkg::RATIO_ONE - r) * d) + (z << 24) - 1) / (z << 24);
      else
         step = (s + 255) / 256;
      if (step < 1) step = 1;
      if (d <= step)
         nxt = tgt;
      else if (pos < tgt)
         nxt = pos + longint'(step);
      else
         nxt = pos - longint'(step);
      if (nxt < 0) nxt = 0;
      if (nxt > longint'(prs_pkg::POS_LIMIT)) nxt = prs_pkg::POS_LIMIT;
      return nxt[prs_pkg::POS_W-1:0];
   endfunction

   task automatic send_target(input logic signed [prs_pkg::TARGET_W-1:0] target);
      logic [prs_pkg::POS_W-1:0] pos;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         req_target <= prs_pkg::TARGET_W'($urandom);
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_target <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pos = next_position(target);
      cur_pos = pos;
      expected_positions.push_back(pos);
      @(negedge clock);
   endtask

   // stop sending and let every outstanding request drain
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic program_ramp(input logic [prs_pkg::CSR_DATA_W-1:0] step_val,
                               input logic [prs_pkg::CSR_DATA_W-1:0] zone_val,
                               input logic [prs_pkg::CSR_DATA_W-1:0] ratio_val);
      logic [prs_pkg::CSR_IDX_W-1:0]  idx[3];
      logic [prs_pkg::CSR_DATA_W-1:0] val[3];
      idx = '{prs_pkg::REG_MAX_STEP, prs_pkg::REG_SLOW_ZONE, prs_pkg::REG_MIN_RATIO};
      val = '{step_val, zone_val, ratio_val};
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[i])
            prs_pkg::REG_MAX_STEP: begin
               cfg_step = val[i][prs_pkg::SPEED_W-1:0];
            end
            prs_pkg::REG_SLOW_ZONE: begin
               cfg_zone = val[i][prs_pkg::ZONE_W-1:0];
            end
            prs_pkg::REG_MIN_RATIO: begin
               cfg_ratio = val[i][prs_pkg::RATIO_W-1:0];
            end
            default: begin
            end
         endcase
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_settings();
      send_target(prs_pkg::TARGET_W'(0));
      send_target(prs_pkg::TARGET_W'(7));
      send_target(prs_pkg::TARGET_W'(-3));
      send_target(prs_pkg::TARGET_W'(65535));
   endtask

   task automatic test_full_step();
      settle();
      program_ramp(20'hFFFFF, '0, prs_pkg::CSR_DATA_W'(prs_pkg::RATIO_ONE));
      repeat (8) send_target(prs_pkg::TARGET_W'(65535));
      send_target(prs_pkg::TARGET_W'(-65536));
   endtask

   task automatic test_small_steps();
      settle();
      program_ramp('0, prs_pkg::CSR_DATA_W'(65535), '0);
      send_target(prs_pkg::TARGET_W'(3));
      send_target(prs_pkg::TARGET_W'(-1));
   endtask

   task automatic test_ratio_saturation();
      settle();
      program_ramp(prs_pkg::CSR_DATA_W'(5000), prs_pkg::CSR_DATA_W'(300),
                   prs_pkg::CSR_DATA_W'(131071));
      send_target(prs_pkg::TARGET_W'(int'(cur_pos) + 250));
      send_target(prs_pkg::TARGET_W'(int'(cur_pos) - 260));
   endtask

   task automatic test_random_traffic(input int items);
      logic signed [prs_pkg::TARGET_W-1:0] goal;
      logic [prs_pkg::CSR_DATA_W-1:0]      step_val, zone_val, ratio_val;
      int run_left, span, cand;
      settle();
      step_val = ($urandom_range(0, 3) == 0)
               ? prs_pkg::CSR_DATA_W'($urandom_range(0, 20'hFFFFF))
               : prs_pkg::CSR_DATA_W'($urandom_range(0, 8191));
      case ($urandom_range(0, 9))
         0: zone_val = '0;
         1: zone_val = prs_pkg::CSR_DATA_W'(65535);
         2: zone_val = prs_pkg::CSR_DATA_W'($urandom_range(1, 65535));
         default: zone_val = prs_pkg::CSR_DATA_W'($urandom_range(1, 8000));
      endcase
      case ($urandom_range(0, 9))
         0: ratio_val = '0;
         1: ratio_val = prs_pkg::CSR_DATA_W'(prs_pkg::RATIO_ONE);
         2: ratio_val = prs_pkg::CSR_DATA_W'($urandom_range(prs_pkg::RATIO_ONE + 1, 131071));
         default: ratio_val = prs_pkg::CSR_DATA_W'($urandom_range(1, prs_pkg::RATIO_ONE - 1));
      endcase
      program_ramp(step_val, zone_val, ratio_val);
      goal = '0;
      run_left = 0;
      repeat (items) begin
         // hold one goal for a run of ticks so the ramp can reach and settle on it
         if (run_left == 0) begin
            run_left = $urandom_range(1, 12);
            case ($urandom_range(0, 19))
               0, 1, 2: goal = prs_pkg::TARGET_W'($urandom);
               3, 4, 5: goal = prs_pkg::TARGET_W'(cur_pos);
               default: begin
                  span = int'(cfg_zone) + int'(cfg_step >> 8) + 4;
                  cand = int'(cur_pos) - span + int'($urandom_range(0, 2 * span));
                  if (cand < -65536) cand = -65536;
                  if (cand > 65535) cand = 65535;
                  goal = prs_pkg::TARGET_W'(cand);
               end
            endcase
         end
         run_left--;
         send_target(goal);
      end
   endtask

   task automatic test_response_hold();
      settle();
      hold_left = HOLD_CYCLES;
      repeat (12) send_target(prs_pkg::TARGET_W'($urandom));
   endtask

   task automatic test_sender_pause();
      repeat (3) begin
         repeat (8)
            send_target(prs_pkg::TARGET_W'(int'(cur_pos) + $urandom_range(0, 40) - 20));
         settle();
      end
   endtask

   // response side stall: long hold on request, otherwise random bursts while idle_on is set
   initial begin
      rsp_stall = 1'b0;
      burst_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 14) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_positions.size() == 0) begin
            errors++;
            $display("%0t: position expected none actual %0d", $time, rsp_position);
         end else begin
            due_position = expected_positions.pop_front();
            if (rsp_position !== due_position) begin
               errors++;
               $display("%0t: position expected %0d actual %0d",
                        $time, due_position, rsp_position);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_target = '0;
      csr_valid = 1'b0;
      csr_index = prs_pkg::REG_MAX_STEP;
      csr_data = '0;
      hold_left = 0;
      idle_on = 1'b1;
      errors = 0;
      cycle_count = 0;
      cfg_step = prs_pkg::SPEED_W'(2560);
      cfg_zone = prs_pkg::ZONE_W'(4200);
      cfg_ratio = prs_pkg::RATIO_W'(6554);
      cur_pos = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_settings();
      test_full_step();
      test_small_steps();
      test_ratio_saturation();
      repeat (4) test_random_traffic(100);
      test_response_hold();
      test_sender_pause();
      idle_on = 1'b0;
      test_random_traffic(100);
      settle();

      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
